// File: rtl/toeplitz_levinson_solver_core_assert.svh
// ----------------------------------------------------------------------------
// Toeplitz solver assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef TOEPLITZ_LEVINSON_SOLVER_CORE_ASSERT_SVH
`define TOEPLITZ_LEVINSON_SOLVER_CORE_ASSERT_SVH

// same-cycle implication
`define TLS_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TLS_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tls_pkg.sv
// ----------------------------------------------------------------------------
// Toeplitz solver package
// Item kinds, status codes, register map and work memory regions.
// ----------------------------------------------------------------------------
`default_nettype none

package tls_pkg;

    typedef logic signed [31:0] fx_t;

    localparam logic [1:0] KIND_DIAG  = 2'd0;
    localparam logic [1:0] KIND_RHS   = 2'd1;
    localparam logic [1:0] KIND_SOLVE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_ZDIAG   = 2'd1;
    localparam logic [1:0] STAT_ZFWD    = 2'd2;
    localparam logic [1:0] STAT_ZBWD    = 2'd3;

    localparam logic [1:0] REG_ORDER       = 2'd0;
    localparam logic [5:0] ORDER_RESET     = 6'd1;

    // work memory regions
    localparam logic [1:0] RGN_Y = 2'd0;
    localparam logic [1:0] RGN_X = 2'd1;
    localparam logic [1:0] RGN_G = 2'd2;
    localparam logic [1:0] RGN_H = 2'd3;

endpackage

`default_nettype wire

// File: rtl/toeplitz_levinson_solver_core.sv
// ----------------------------------------------------------------------------
// Toeplitz Levinson solver core
// Solves T x = y for a general Toeplitz matrix by Levinson recursion, Q16.16.
// ----------------------------------------------------------------------------
// Load beats (diagonal / right-hand side) leave busy low. A solve beat is
// paced by one shared 32x32 multiplier and a bit-serial divider of
// 32+FRAC_BITS steps. Each result beat needs its own read of the work
// memory; results cannot be stalled. Async active-low reset clears
// control and sets order to 1; the memories are not cleared.
`default_nettype none

module toeplitz_levinson_solver_core #(
    parameter int MAX_ORDER = 32,
    parameter int FRAC_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // command channel
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         kind,
    input  wire logic [5:0]         index,
    input  wire logic signed [31:0] value,
    // result channel
    output logic                    result_valid,
    output logic [4:0]              position,
    output logic signed [31:0]      solution_value,
    output logic                    last,
    output logic [1:0]              status,
    // APB register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [1:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // ------------------------------------------------------------------
    // Sizes
    // ------------------------------------------------------------------
    localparam int IW     = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
    localparam int DDEPTH = 2 * MAX_ORDER - 1;
    localparam int DW     = (MAX_ORDER > 1) ? $clog2(DDEPTH) : 1;
    localparam int WDEPTH = 4 << IW;
    localparam int WA     = IW + 2;
    localparam int NW     = 32 + FRAC_BITS;      // divider dividend / quotient
    localparam int CW     = $clog2(NW);

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;
    localparam logic signed [63:0] RND_BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_I_RD   = 5'd1;
    localparam logic [4:0] S_I_CHK  = 5'd2;
    localparam logic [4:0] S_I_RD2  = 5'd3;
    localparam logic [4:0] S_I_G0   = 5'd4;
    localparam logic [4:0] S_I_RD3  = 5'd5;
    localparam logic [4:0] S_I_H0   = 5'd6;
    localparam logic [4:0] S_DV_RUN = 5'd7;
    localparam logic [4:0] S_DV_FIN = 5'd8;
    localparam logic [4:0] S_DT_INI = 5'd9;
    localparam logic [4:0] S_DT_INW = 5'd10;
    localparam logic [4:0] S_DT_RD  = 5'd11;
    localparam logic [4:0] S_DT_MUL = 5'd12;
    localparam logic [4:0] S_DT_ACC = 5'd13;
    localparam logic [4:0] S_DT_END = 5'd14;
    localparam logic [4:0] S_XU_RDG = 5'd15;
    localparam logic [4:0] S_XU_RDX = 5'd16;
    localparam logic [4:0] S_XU_WR  = 5'd17;
    localparam logic [4:0] S_PU0    = 5'd18;
    localparam logic [4:0] S_PU1    = 5'd19;
    localparam logic [4:0] S_PU2    = 5'd20;
    localparam logic [4:0] S_PU3    = 5'd21;
    localparam logic [4:0] S_PU4    = 5'd22;
    localparam logic [4:0] S_PU5    = 5'd23;
    localparam logic [4:0] S_PU6    = 5'd24;
    localparam logic [4:0] S_PU7    = 5'd25;
    localparam logic [4:0] S_PU8    = 5'd26;
    localparam logic [4:0] S_EM_RD  = 5'd27;
    localparam logic [4:0] S_EM_CAP = 5'd28;
    localparam logic [4:0] S_DONE   = 5'd29;

    // dot product selector: which sum the shared accumulate loop builds
    localparam logic [2:0] DOT_SXN = 3'd0;
    localparam logic [2:0] DOT_SD  = 3'd1;
    localparam logic [2:0] DOT_SGN = 3'd2;
    localparam logic [2:0] DOT_SHN = 3'd3;
    localparam logic [2:0] DOT_SGD = 3'd4;

    // divider destination
    localparam logic [2:0] DT_X0 = 3'd0;
    localparam logic [2:0] DT_G0 = 3'd1;
    localparam logic [2:0] DT_H0 = 3'd2;
    localparam logic [2:0] DT_XM = 3'd3;
    localparam logic [2:0] DT_GM = 3'd4;
    localparam logic [2:0] DT_HM = 3'd5;

    // ------------------------------------------------------------------
    // Fixed-point helpers
    // ------------------------------------------------------------------
    function automatic logic signed [31:0] f_sat(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
            r = 32'sh7fffffff;
        else if (v < SAT_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // product already formed; truncate toward zero, then saturate
    function automatic logic signed [31:0] f_mul(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p + (p[63] ? RND_BIAS : 64'sd0);
        return f_sat(t >>> FRAC_BITS);
    endfunction

    function automatic logic signed [31:0] f_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] s;
        s = {{32{a[31]}}, a} + {{32{b[31]}}, b};
        return f_sat(s);
    endfunction

    function automatic logic signed [31:0] f_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] s;
        s = {{32{a[31]}}, a} - {{32{b[31]}}, b};
        return f_sat(s);
    endfunction

    function automatic logic signed [31:0] f_neg(input logic signed [31:0] a);
        logic signed [63:0] s;
        s = 64'sd0 - {{32{a[31]}}, a};
        return f_sat(s);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [4:0]          state_reg;
    logic [5:0]          order_reg;
    logic [IW-1:0]       n1_reg;
    logic [IW-1:0]       m_reg;
    logic [IW-1:0]       j_reg;
    logic [2:0]          dsel_reg;
    logic [2:0]          tag_reg;
    tls_pkg::fx_t        acc_reg, piv_reg, sxn_reg, sd_reg, sgn_reg, shn_reg;
    tls_pkg::fx_t        xm1_reg, pp_reg, qq_reg;
    tls_pkg::fx_t        pt1_reg, pt2_reg, qt1_reg, qt2_reg;
    logic signed [63:0]  prod_reg;

    // divider
    logic [NW-1:0]       dv_n_reg;
    logic [32:0]         dv_rem_reg;
    logic [31:0]         dv_den_reg;
    logic                dv_neg_reg;
    logic [CW-1:0]       dv_cnt_reg;

    // results
    logic                rv_reg;
    logic [4:0]          pos_reg;
    tls_pkg::fx_t        sol_reg;
    logic                last_reg;
    logic [1:0]          stat_reg;

    // memories
    logic [31:0]         dg_mem [0:DDEPTH-1];
    logic [31:0]         wk_mem [0:WDEPTH-1];
    tls_pkg::fx_t        dg_rd, wk_rd;

    // ------------------------------------------------------------------
    // Index arithmetic
    // ------------------------------------------------------------------
    logic [IW-1:0]  m1, mj, k_idx;
    logic [DW:0]    e_n1, e_m1, e_j;
    logic [DW-1:0]  r_fwd, r_bwd, r_lo, r_hi, r_dn, r_up, r_mid;

    always_comb
    begin
        m1    = m_reg + 1'b1;
        mj    = m_reg - j_reg;
        k_idx = mj;
        e_n1  = (DW+1)'(n1_reg);
        e_m1  = (DW+1)'(m1);
        e_j   = (DW+1)'(j_reg);
        r_fwd = DW'(e_n1 + e_m1 - e_j);          // r[n1+m1-j]
        r_bwd = DW'(e_n1 + e_j - e_m1);          // r[n1+j-m1]
        r_lo  = DW'(e_n1 - e_m1 - 1'b1);         // r[n1-m1-1]
        r_hi  = DW'(e_n1 + e_m1 + 1'b1);         // r[n1+m1+1]
        r_dn  = DW'(e_n1 - 1'b1);
        r_up  = DW'(e_n1 + 1'b1);
        r_mid = DW'(e_n1);
    end

    // ------------------------------------------------------------------
    // Divider step and result
    // ------------------------------------------------------------------
    logic [32:0]   dv_rsh;
    logic          dv_ge;
    tls_pkg::fx_t  dv_q;

    always_comb
    begin
        dv_rsh = {dv_rem_reg[31:0], dv_n_reg[NW-1]};
        dv_ge  = (dv_rsh >= {1'b0, dv_den_reg});
        if (!dv_neg_reg)
            dv_q = (dv_n_reg > NW'(32'h7fffffff)) ? 32'sh7fffffff : dv_n_reg[31:0];
        else if (dv_n_reg > NW'(33'h080000000))
            dv_q = 32'sh80000000;
        else
            dv_q = 32'(32'd0 - dv_n_reg[31:0]);
    end

    // divider launch
    logic          dv_go;
    tls_pkg::fx_t  dv_a, dv_b;

    always_comb
    begin
        dv_go = 1'b0;
        dv_a  = wk_rd;
        dv_b  = dg_rd;
        case (state_reg)
            S_I_CHK:
            begin
                dv_go = (dg_rd != 32'sd0);
            end
            S_I_G0, S_I_H0:
            begin
                dv_go = 1'b1;
                dv_a  = dg_rd;
                dv_b  = piv_reg;
            end
            S_DT_END:
            begin
                dv_b = acc_reg;
                if (dsel_reg == DOT_SD)
                begin
                    dv_go = (acc_reg != 32'sd0);
                    dv_a  = sxn_reg;
                end
                else if (dsel_reg == DOT_SGD)
                begin
                    dv_go = (acc_reg != 32'sd0);
                    dv_a  = sgn_reg;
                end
            end
            S_DV_FIN:
            begin
                dv_go = (tag_reg == DT_GM);
                dv_a  = shn_reg;
                dv_b  = sd_reg;
            end
            default:
            begin
                dv_go = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    logic            dg_we;
    logic [DW-1:0]   dg_waddr, dg_raddr;
    logic            wk_we;
    logic [WA-1:0]   wk_waddr, wk_raddr;
    tls_pkg::fx_t    wk_wdata;
    logic            cmd_acc;

    assign cmd_acc  = start && !busy;
    assign dg_we    = cmd_acc && (kind == tls_pkg::KIND_DIAG)
                      && ({1'b0, index} < 7'(DDEPTH));
    assign dg_waddr = DW'(index);

    always_comb
    begin
        dg_raddr = r_mid;
        wk_raddr = {tls_pkg::RGN_Y, IW'(0)};
        case (state_reg)
            S_I_RD:   dg_raddr = r_mid;
            S_I_RD2:  dg_raddr = r_dn;
            S_I_RD3:  dg_raddr = r_up;
            S_DT_INI:
            begin
                wk_raddr = {tls_pkg::RGN_Y, m1};
                case (dsel_reg)
                    DOT_SGN: dg_raddr = r_lo;
                    DOT_SHN: dg_raddr = r_hi;
                    default: dg_raddr = r_mid;
                endcase
            end
            S_DT_RD:
            begin
                case (dsel_reg)
                    DOT_SXN:
                    begin
                        dg_raddr = r_fwd;
                        wk_raddr = {tls_pkg::RGN_X, j_reg};
                    end
                    DOT_SD:
                    begin
                        dg_raddr = r_fwd;
                        wk_raddr = {tls_pkg::RGN_G, mj};
                    end
                    DOT_SGN:
                    begin
                        dg_raddr = r_bwd;
                        wk_raddr = {tls_pkg::RGN_G, j_reg};
                    end
                    DOT_SHN:
                    begin
                        dg_raddr = r_fwd;
                        wk_raddr = {tls_pkg::RGN_H, j_reg};
                    end
                    default:
                    begin
                        dg_raddr = r_bwd;
                        wk_raddr = {tls_pkg::RGN_H, mj};
                    end
                endcase
            end
            S_XU_RDG: wk_raddr = {tls_pkg::RGN_G, mj};
            S_XU_RDX: wk_raddr = {tls_pkg::RGN_X, j_reg};
            S_PU0:    wk_raddr = {tls_pkg::RGN_G, j_reg};
            S_PU1:    wk_raddr = {tls_pkg::RGN_G, k_idx};
            S_PU2:    wk_raddr = {tls_pkg::RGN_H, j_reg};
            S_PU3:    wk_raddr = {tls_pkg::RGN_H, k_idx};
            S_EM_RD:  wk_raddr = {tls_pkg::RGN_X, j_reg};
            default:  dg_raddr = r_mid;
        endcase
    end

    always_comb
    begin
        wk_we    = 1'b0;
        wk_waddr = {tls_pkg::RGN_Y, IW'(index)};
        wk_wdata = value;
        case (state_reg)
            S_IDLE:
            begin
                wk_we = cmd_acc && (kind == tls_pkg::KIND_RHS)
                        && ({1'b0, index} < 7'(MAX_ORDER));
            end
            S_DV_FIN:
            begin
                wk_we    = 1'b1;
                wk_wdata = dv_q;
                case (tag_reg)
                    DT_X0:   wk_waddr = {tls_pkg::RGN_X, IW'(0)};
                    DT_G0:   wk_waddr = {tls_pkg::RGN_G, IW'(0)};
                    DT_H0:   wk_waddr = {tls_pkg::RGN_H, IW'(0)};
                    DT_XM:   wk_waddr = {tls_pkg::RGN_X, m1};
                    DT_GM:   wk_waddr = {tls_pkg::RGN_G, m1};
                    default: wk_waddr = {tls_pkg::RGN_H, m1};
                endcase
            end
            S_XU_WR:
            begin
                wk_we    = 1'b1;
                wk_waddr = {tls_pkg::RGN_X, j_reg};
                wk_wdata = f_sub(wk_rd, f_mul(prod_reg));
            end
            S_PU5:
            begin
                wk_we    = 1'b1;
                wk_waddr = {tls_pkg::RGN_G, j_reg};
                wk_wdata = f_sub(pt1_reg, f_mul(prod_reg));
            end
            S_PU6:
            begin
                wk_we    = 1'b1;
                wk_waddr = {tls_pkg::RGN_G, k_idx};
                wk_wdata = f_sub(pt2_reg, f_mul(prod_reg));
            end
            S_PU7:
            begin
                wk_we    = 1'b1;
                wk_waddr = {tls_pkg::RGN_H, j_reg};
                wk_wdata = f_sub(qt1_reg, f_mul(prod_reg));
            end
            S_PU8:
            begin
                wk_we    = 1'b1;
                wk_waddr = {tls_pkg::RGN_H, k_idx};
                wk_wdata = f_sub(qt2_reg, f_mul(prod_reg));
            end
            default:
            begin
                wk_we = 1'b0;
            end
        endcase
    end

    // Accesses are strictly sequential: every read of an entry is issued
    // in a later cycle than its write, so no forwarding is needed.
    always_ff @(posedge clk)
    begin
        if (dg_we)
            dg_mem[dg_waddr] <= value;
        if (wk_we)
            wk_mem[wk_waddr] <= wk_wdata;
        dg_rd <= dg_mem[dg_raddr];
        wk_rd <= wk_mem[wk_raddr];
    end

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = (paddr == tls_pkg::REG_ORDER) ? {26'd0, order_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            order_reg <= tls_pkg::ORDER_RESET;
        else if (psel && penable && pwrite && (paddr == tls_pkg::REG_ORDER))
            order_reg <= pwdata[5:0];
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [IW-1:0] n1_start;

    always_comb
    begin
        if (order_reg == 6'd0)
            n1_start = IW'(0);
        else if ({1'b0, order_reg} > 7'(MAX_ORDER))
            n1_start = IW'(MAX_ORDER - 1);
        else
            n1_start = IW'(order_reg - 6'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_acc && (kind == tls_pkg::KIND_SOLVE))
                    begin
                        n1_reg    <= n1_start;
                        state_reg <= S_I_RD;
                    end
                end
                S_I_RD:
                begin
                    state_reg <= S_I_CHK;
                end
                S_I_CHK:
                begin
                    piv_reg <= dg_rd;
                    tag_reg <= DT_X0;
                    if (dg_rd == 32'sd0)
                    begin
                        rv_reg    <= 1'b1;
                        pos_reg   <= 5'd0;
                        sol_reg   <= 32'sd0;
                        last_reg  <= 1'b1;
                        stat_reg  <= tls_pkg::STAT_ZDIAG;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_DV_RUN;
                end
                S_I_RD2:
                begin
                    state_reg <= S_I_G0;
                end
                S_I_G0:
                begin
                    tag_reg   <= DT_G0;
                    state_reg <= S_DV_RUN;
                end
                S_I_RD3:
                begin
                    state_reg <= S_I_H0;
                end
                S_I_H0:
                begin
                    tag_reg   <= DT_H0;
                    state_reg <= S_DV_RUN;
                end
                S_DV_RUN:
                begin
                    if (dv_cnt_reg == CW'(NW - 1))
                        state_reg <= S_DV_FIN;
                end
                S_DV_FIN:
                begin
                    j_reg <= '0;
                    case (tag_reg)
                        DT_X0:
                        begin
                            if (n1_reg == '0)
                                state_reg <= S_EM_RD;
                            else
                                state_reg <= S_I_RD2;
                        end
                        DT_G0:
                        begin
                            state_reg <= S_I_RD3;
                        end
                        DT_H0:
                        begin
                            m_reg     <= '0;
                            dsel_reg  <= DOT_SXN;
                            state_reg <= S_DT_INI;
                        end
                        DT_XM:
                        begin
                            xm1_reg   <= dv_q;
                            state_reg <= S_XU_RDG;
                        end
                        DT_GM:
                        begin
                            pp_reg    <= dv_q;
                            tag_reg   <= DT_HM;
                            state_reg <= S_DV_RUN;
                        end
                        default:
                        begin
                            qq_reg    <= dv_q;
                            state_reg <= S_PU0;
                        end
                    endcase
                end
                S_DT_INI:
                begin
                    state_reg <= S_DT_INW;
                end
                S_DT_INW:
                begin
                    acc_reg   <= f_neg((dsel_reg == DOT_SXN) ? wk_rd : dg_rd);
                    j_reg     <= '0;
                    state_reg <= S_DT_RD;
                end
                S_DT_RD:
                begin
                    state_reg <= S_DT_MUL;
                end
                S_DT_MUL:
                begin
                    prod_reg  <= dg_rd * wk_rd;
                    state_reg <= S_DT_ACC;
                end
                S_DT_ACC:
                begin
                    acc_reg <= f_add(acc_reg, f_mul(prod_reg));
                    if (j_reg == m_reg)
                        state_reg <= S_DT_END;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_DT_RD;
                    end
                end
                S_DT_END:
                begin
                    case (dsel_reg)
                        DOT_SXN:
                        begin
                            sxn_reg   <= acc_reg;
                            dsel_reg  <= DOT_SD;
                            state_reg <= S_DT_INI;
                        end
                        DOT_SD:
                        begin
                            sd_reg  <= acc_reg;
                            tag_reg <= DT_XM;
                            if (acc_reg == 32'sd0)
                            begin
                                rv_reg    <= 1'b1;
                                pos_reg   <= 5'd0;
                                sol_reg   <= 32'sd0;
                                last_reg  <= 1'b1;
                                stat_reg  <= tls_pkg::STAT_ZFWD;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_DV_RUN;
                        end
                        DOT_SGN:
                        begin
                            sgn_reg   <= acc_reg;
                            dsel_reg  <= DOT_SHN;
                            state_reg <= S_DT_INI;
                        end
                        DOT_SHN:
                        begin
                            shn_reg   <= acc_reg;
                            dsel_reg  <= DOT_SGD;
                            state_reg <= S_DT_INI;
                        end
                        default:
                        begin
                            tag_reg <= DT_GM;
                            if (acc_reg == 32'sd0)
                            begin
                                rv_reg    <= 1'b1;
                                pos_reg   <= 5'd0;
                                sol_reg   <= 32'sd0;
                                last_reg  <= 1'b1;
                                stat_reg  <= tls_pkg::STAT_ZBWD;
                                state_reg <= S_DONE;
                            end
                            else
                                state_reg <= S_DV_RUN;
                        end
                    endcase
                end
                // x[j] -= x[m1] * g[m-j]
                S_XU_RDG:
                begin
                    state_reg <= S_XU_RDX;
                end
                S_XU_RDX:
                begin
                    prod_reg  <= xm1_reg * wk_rd;
                    state_reg <= S_XU_WR;
                end
                S_XU_WR:
                begin
                    if (j_reg == m_reg)
                    begin
                        j_reg <= '0;
                        if (m1 == n1_reg)
                            state_reg <= S_EM_RD;
                        else
                        begin
                            dsel_reg  <= DOT_SGN;
                            state_reg <= S_DT_INI;
                        end
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_XU_RDG;
                    end
                end
                // symmetric pair update of g and h
                S_PU0: state_reg <= S_PU1;
                S_PU1:
                begin
                    pt1_reg   <= wk_rd;
                    state_reg <= S_PU2;
                end
                S_PU2:
                begin
                    pt2_reg   <= wk_rd;
                    state_reg <= S_PU3;
                end
                S_PU3:
                begin
                    qt1_reg   <= wk_rd;
                    state_reg <= S_PU4;
                end
                S_PU4:
                begin
                    qt2_reg   <= wk_rd;
                    prod_reg  <= pp_reg * wk_rd;
                    state_reg <= S_PU5;
                end
                S_PU5:
                begin
                    prod_reg  <= pp_reg * qt1_reg;
                    state_reg <= S_PU6;
                end
                S_PU6:
                begin
                    prod_reg  <= qq_reg * pt2_reg;
                    state_reg <= S_PU7;
                end
                S_PU7:
                begin
                    prod_reg  <= qq_reg * pt1_reg;
                    state_reg <= S_PU8;
                end
                S_PU8:
                begin
                    if (j_reg == (m_reg >> 1))
                    begin
                        m_reg     <= m1;
                        dsel_reg  <= DOT_SXN;
                        state_reg <= S_DT_INI;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_PU0;
                    end
                end
                S_EM_RD:
                begin
                    state_reg <= S_EM_CAP;
                end
                S_EM_CAP:
                begin
                    rv_reg   <= 1'b1;
                    pos_reg  <= 5'(j_reg);
                    sol_reg  <= wk_rd;
                    last_reg <= (j_reg == n1_reg);
                    stat_reg <= tls_pkg::STAT_OK;
                    if (j_reg == n1_reg)
                        state_reg <= S_DONE;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_EM_RD;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Bit-serial restoring divider on magnitudes: |a| * 2^FRAC_BITS / |b|
    always_ff @(posedge clk)
    begin
        if (dv_go)
        begin
            dv_neg_reg <= dv_a[31] ^ dv_b[31];
            dv_n_reg   <= {(dv_a[31] ? 32'(32'd0 - dv_a) : 32'(dv_a)),
                           {FRAC_BITS{1'b0}}};
            dv_den_reg <= dv_b[31] ? 32'(32'd0 - dv_b) : 32'(dv_b);
            dv_rem_reg <= '0;
            dv_cnt_reg <= '0;
        end
        else if (state_reg == S_DV_RUN)
        begin
            dv_rem_reg <= dv_ge ? (dv_rsh - {1'b0, dv_den_reg}) : dv_rsh;
            dv_n_reg   <= {dv_n_reg[NW-2:0], dv_ge};
            dv_cnt_reg <= dv_cnt_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign busy           = (state_reg != S_IDLE);
    assign result_valid   = rv_reg;
    assign position       = pos_reg;
    assign solution_value = sol_reg;
    assign last           = last_reg;
    assign status         = stat_reg;

endmodule

`default_nettype wire

// File: rtl/tls_chk.sv
// ----------------------------------------------------------------------------
// Toeplitz solver port checker
// Watches the command and result ports of the solver core over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "toeplitz_levinson_solver_core_assert.svh"

module tls_chk (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  kind,
    input wire logic        result_valid,
    input wire logic [4:0]  position,
    input wire logic [31:0] solution_value,
    input wire logic        last,
    input wire logic [1:0]  status
);

    `TLS_AST_NOW(a_res_in_solve, result_valid, busy, "result beat outside a solve")
    `TLS_AST_NXT(a_solve_busy, start && !busy && (kind == tls_pkg::KIND_SOLVE), busy, "solve not taken")
    `TLS_AST_NXT(a_last_ends, result_valid && last, !result_valid, "beat after last")
    `TLS_AST_NOW(a_err_shape, result_valid && (status != tls_pkg::STAT_OK), last && (position == 5'd0) && (solution_value == 32'd0), "malformed error beat")
    `TLS_AST_NXT(a_more_due, result_valid && !last, busy, "solve ended early")

endmodule

bind toeplitz_levinson_solver_core tls_chk u_tls_chk (.*);

`default_nettype wire
